// File: hw/rtl/flr_pkg.sv
// flr_pkg: shared constants, codes and request type of the line rasterizer
// used by flr_stepper, flr_store and framebuffer_line_rasterizer
// no dependencies
package flr_pkg;

    // screen geometry and store size
    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;
    localparam int STORE_BYTES    = 1024;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    // field widths
    localparam int COORD_W = 10;
    localparam int CNT_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    // wide enough for column + page * SCREEN_COLUMNS at the largest screen
    localparam int IDX_W   = 20;

    // stream widths, whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // command opcodes
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // store request kinds
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // one access into the store pipeline
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bitsel;
        logic              ink;
    } req_t;

endpackage

// File: hw/rtl/flr_stepper.sv
// flr_stepper: bresenham walker, one pixel per cycle, clips to the screen
// emits pixel write requests for the store; depends on flr_pkg
module flr_stepper
    import flr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    input  logic                      ink,
    output logic                      busy,
    output req_t                      req
);

    logic                      active_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, xe_reg, ye_reg;
    logic [COORD_W:0]          dx_reg, dy_reg;
    logic signed [12:0]        err_reg;
    logic                      sxn_reg, syn_reg, ink_reg;
    req_t                      req_reg;

    logic [COORD_W:0]          dxs, dys, dx0, dy0;
    logic signed [13:0]        e2, ndy;
    logic                      step_x, step_y, at_end;
    logic signed [12:0]        err_next;
    logic                      on_screen;
    logic [IDX_W-1:0]          idx_w;
    req_t                      req_next;

    // setup: absolute deltas of the new line
    always_comb begin
        dxs = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
        dys = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
        dx0 = dxs[COORD_W] ? ((COORD_W+1)'(0) - dxs) : dxs;
        dy0 = dys[COORD_W] ? ((COORD_W+1)'(0) - dys) : dys;
    end

    // error term update
    always_comb begin
        e2       = {err_reg, 1'b0};
        ndy      = 14'sd0 - $signed({3'b000, dy_reg});
        step_x   = e2 > ndy;
        step_y   = e2 < $signed({3'b000, dx_reg});
        err_next = err_reg - (step_x ? $signed({2'b00, dy_reg}) : 13'sd0)
                           + (step_y ? $signed({2'b00, dx_reg}) : 13'sd0);
        at_end   = (x_reg == xe_reg) && (y_reg == ye_reg);
    end

    // clipping and byte address of the current pixel
    always_comb begin
        idx_w = IDX_W'(x_reg[COORD_W-2:0])
              + IDX_W'(y_reg[COORD_W-2:3]) * IDX_W'(SCREEN_COLUMNS);
        on_screen = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                 && ({1'b0, x_reg} < (COORD_W+1)'(SCREEN_COLUMNS))
                 && ({1'b0, y_reg} < (COORD_W+1)'(SCREEN_ROWS))
                 && (idx_w < IDX_W'(STORE_BYTES));
        req_next.valid  = active_reg && on_screen;
        req_next.kind   = REQ_PIXEL;
        req_next.addr   = idx_w[ADDR_W-1:0];
        req_next.bitsel = y_reg[2:0];
        req_next.ink    = ink_reg;
    end

    // walker registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            req_reg.valid <= 1'b0;
        end else begin
            req_reg <= req_next;
            if (start) begin
                active_reg <= 1'b1;
                x_reg      <= start_x;
                y_reg      <= start_y;
                xe_reg     <= end_x;
                ye_reg     <= end_y;
                dx_reg     <= dx0;
                dy_reg     <= dy0;
                err_reg    <= $signed({2'b00, dx0}) - $signed({2'b00, dy0});
                sxn_reg    <= !(start_x < end_x);
                syn_reg    <= !(start_y < end_y);
                ink_reg    <= ink;
            end else if (active_reg) begin
                if (at_end) begin
                    active_reg <= 1'b0;
                end else begin
                    err_reg <= err_next;
                    if (step_x) begin
                        x_reg <= sxn_reg ? x_reg - 10'sd1 : x_reg + 10'sd1;
                    end
                    if (step_y) begin
                        y_reg <= syn_reg ? y_reg - 10'sd1 : y_reg + 10'sd1;
                    end
                end
            end
        end
    end

    assign busy = active_reg;
    assign req  = req_reg;

endmodule

// File: hw/rtl/flr_store.sv
// flr_store: frame byte memory with a read-modify-write pipeline
// one request per cycle, forwarding of the previous write; depends on flr_pkg
module flr_store
    import flr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  req_t              req,
    output logic              rd_valid,
    output logic [BYTE_W-1:0] rd_data,
    output logic              busy
);

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_q;

    req_t              s1_reg;
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic [BYTE_W-1:0] old_byte, new_byte, mask;
    logic              we;

    // merge the byte just written when it is read again right away
    always_comb begin
        old_byte = (fwd_valid_reg && (fwd_addr_reg == s1_reg.addr)) ? fwd_data_reg : rd_q;
        mask     = BYTE_W'(1) << s1_reg.bitsel;
        we       = s1_reg.valid && (s1_reg.kind != REQ_READ);
        unique case (s1_reg.kind)
            REQ_PIXEL: new_byte = s1_reg.ink ? (old_byte | mask) : (old_byte & ~mask);
            REQ_CLEAR: new_byte = '0;
            default:   new_byte = old_byte;
        endcase
    end

    // memory: read at the incoming address, write back the modified byte
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[s1_reg.addr] <= new_byte;
        end
        rd_q <= mem[req.addr];
    end

    // pipeline stage and forwarding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s1_reg        <= req;
            fwd_valid_reg <= we;
            fwd_addr_reg  <= s1_reg.addr;
            fwd_data_reg  <= new_byte;
        end
    end

    assign rd_valid = s1_reg.valid && (s1_reg.kind == REQ_READ);
    assign rd_data  = old_byte;
    assign busy     = s1_reg.valid;

endmodule

// File: hw/rtl/framebuffer_line_rasterizer.sv
// framebuffer_line_rasterizer: command sequencer and result register
// instantiates flr_stepper and flr_store; depends on flr_pkg
//
//  channel  | dir | tdata fields, lowest bit up
//  s_       | in  | opcode, start_x, start_y, end_x, end_y, ink, read_index
//  m_       | out | read_byte, pixels_written
//
// draw: the stepper walks the line, one pixel a cycle through the single store
// port, then the store drains and the result is set; read: one store access;
// clear: every byte cleared, one byte written per cycle.
// after reset a clearing pass over all 1024 bytes runs before s_tready rises.
// one command at a time; the next is taken while a result waits on m_.
module framebuffer_line_rasterizer
    import flr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[1:0], start_x[11:2], start_y[21:12], end_x[31:22], end_y[41:32],
    // ink[42], read_index[52:43]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_byte[7:0], pixels_written[18:8]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DRAW   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 pend_reg, pend_next;
    req_t                 top_req_reg, top_req_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [OP_W-1:0]           f_opcode;
    logic signed [COORD_W-1:0] f_start_x, f_start_y, f_end_x, f_end_y;
    logic                      f_ink;
    logic [ADDR_W-1:0]         f_read_index;

    logic              s_accept, step_start, step_busy, store_busy, rd_valid;
    logic [BYTE_W-1:0] rd_data;
    req_t              step_req, store_req;

    // request fields
    assign f_opcode     = s_tdata[1:0];
    assign f_start_x    = s_tdata[11:2];
    assign f_start_y    = s_tdata[21:12];
    assign f_end_x      = s_tdata[31:22];
    assign f_end_y      = s_tdata[41:32];
    assign f_ink        = s_tdata[42];
    assign f_read_index = s_tdata[52:43];

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign step_start = s_accept && (f_opcode == OP_DRAW);

    flr_stepper u_stepper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (step_start),
        .start_x (f_start_x),
        .start_y (f_start_y),
        .end_x   (f_end_x),
        .end_y   (f_end_y),
        .ink     (f_ink),
        .busy    (step_busy),
        .req     (step_req)
    );

    // pixel writes and sequencer accesses never overlap
    assign store_req = step_req.valid ? step_req : top_req_reg;

    flr_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (store_req),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .busy     (store_busy)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pend_next     = pend_reg;
        top_req_next  = '0;
        count_next    = count_reg;
        byte_next     = byte_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (step_req.valid) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (rd_valid) begin
            byte_next = rd_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                top_req_next.valid = 1'b1;
                top_req_next.kind  = REQ_CLEAR;
                top_req_next.addr  = clr_cnt_reg;
                clr_cnt_next       = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    count_next = '0;
                    byte_next  = '0;
                    pend_next  = 1'b1;
                    unique case (f_opcode)
                        OP_DRAW: begin
                            state_next = ST_DRAW;
                        end
                        OP_READ: begin
                            top_req_next.valid = 1'b1;
                            top_req_next.kind  = REQ_READ;
                            top_req_next.addr  = f_read_index;
                            state_next         = ST_DRAIN;
                        end
                        OP_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                if (!step_busy) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!step_req.valid && !top_req_reg.valid && !store_busy) begin
                    state_next = pend_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - CNT_W - BYTE_W)'(0), count_reg, byte_reg};
                    pend_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            top_req_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_reg     <= pend_next;
            top_req_reg  <= top_req_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        byte_reg    <= byte_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/flr_checker.sv
// flr_checker: port-level checks of the line rasterizer, bound to the top level
// depends on flr_pkg and framebuffer_line_rasterizer
module flr_checker
    import flr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // no result pending right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy right after acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a result carries either a read byte or a pixel count, never both
    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'd0) || (m_tdata[18:8] == 11'd0))
        else $error("read byte and pixel count both nonzero");

    // pixel count bounded by the store size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:8] <= 11'd1024))
        else $error("pixel count out of range");

endmodule

bind framebuffer_line_rasterizer flr_checker u_flr_checker (.*);

// File: bench/tb_framebuffer_line_rasterizer.sv
// tb_framebuffer_line_rasterizer: self-checking bench for the line rasterizer
// drives draw, read and clear requests in random bursts against a mirror of the frame store
// depends on flr_pkg and framebuffer_line_rasterizer
`timescale 1ns / 1ps

module tb_framebuffer_line_rasterizer;
    import flr_pkg::*;

    // opcode with no function, must answer with an all-zero result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS     = 1100;
    localparam int DRAIN_AT         = 550;
    localparam int HOLD_AFTER       = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 64;

    typedef struct {
        logic [OP_W-1:0]           opcode;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      ink;
        logic [ADDR_W-1:0]         read_index;
    } line_cmd_t;

    typedef struct {
        logic [BYTE_W-1:0] read_byte;
        logic [CNT_W-1:0]  pixels_written;
    } fb_result_t;

    typedef struct {
        line_cmd_t  cmd;
        bit         typed;
        fb_result_t want;
    } directed_row_t;

    typedef enum {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_pattern_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // opcode, start_x, start_y, end_x, end_y, ink, read_index, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // read_byte, pixels_written, zero fill
    logic [M_TDATA_W-1:0] m_tdata;

    logic [BYTE_W-1:0] shadow_fb [STORE_BYTES];
    fb_result_t        pending_results [$];
    directed_row_t     directed_rows [$];
    int                mismatches   = 0;
    int                results_seen = 0;
    int                burst_left   = 1;
    int                last_x       = 0;
    int                last_y       = 0;

    framebuffer_line_rasterizer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mirror pixel write; false when off screen or past the store
    function automatic bit plot_pixel(int x, int y, bit ink);
        int idx;
        if (x < 0 || x >= SCREEN_COLUMNS || y < 0 || y >= SCREEN_ROWS)
            return 1'b0;
        idx = x + (y / 8) * SCREEN_COLUMNS;
        if (idx >= STORE_BYTES)
            return 1'b0;
        shadow_fb[idx][y % 8] = ink;
        return 1'b1;
    endfunction

    // bresenham walk, both endpoints included, returns pixels written
    function automatic int trace_line(int x, int y, int xe, int ye, bit ink);
        int dx, dy, sx, sy, err, e2, count;
        dx = (xe > x) ? xe - x : x - xe;
        dy = (ye > y) ? ye - y : y - ye;
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx - dy;
        count = 0;
        while (1'b1) begin
            if (plot_pixel(x, y, ink))
                count++;
            if (x == xe && y == ye)
                break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y += sy;
            end
        end
        return count;
    endfunction

    // apply one request to the mirror and return its result
    function automatic fb_result_t predict_command(line_cmd_t c);
        fb_result_t r;
        r.read_byte      = '0;
        r.pixels_written = '0;
        case (c.opcode)
            OP_DRAW: begin
                r.pixels_written = CNT_W'(trace_line(int'(c.start_x), int'(c.start_y),
                                                     int'(c.end_x), int'(c.end_y), c.ink));
            end
            OP_READ: begin
                r.read_byte = shadow_fb[c.read_index];
            end
            OP_CLEAR: begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // one line of the directed table
    function automatic void add_row(logic [OP_W-1:0] op, int sx, int sy, int ex, int ey,
                                    bit ink, int idx, bit typed, int rb, int pw);
        directed_row_t row;
        row.cmd.opcode          = op;
        row.cmd.start_x         = COORD_W'(sx);
        row.cmd.start_y         = COORD_W'(sy);
        row.cmd.end_x           = COORD_W'(ex);
        row.cmd.end_y           = COORD_W'(ey);
        row.cmd.ink             = ink;
        row.cmd.read_index      = ADDR_W'(idx);
        row.typed               = typed;
        row.want.read_byte      = BYTE_W'(rb);
        row.want.pixels_written = CNT_W'(pw);
        directed_rows.push_back(row);
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // random request, mostly lines near the screen and reads of drawn bytes
    function automatic line_cmd_t random_command();
        line_cmd_t c;
        int pick, shape, bx, by;
        c.start_x    = COORD_W'($urandom);
        c.start_y    = COORD_W'($urandom);
        c.end_x      = COORD_W'($urandom);
        c.end_y      = COORD_W'($urandom);
        c.ink        = 1'($urandom_range(0, 1));
        c.read_index = ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            c.opcode = OP_DRAW;
            shape = $urandom_range(0, 99);
            if (shape < 70) begin
                c.start_x = COORD_W'(rand_between(-16, SCREEN_COLUMNS + 15));
                c.start_y = COORD_W'(rand_between(-16, SCREEN_ROWS + 15));
                c.end_x   = COORD_W'(rand_between(-16, SCREEN_COLUMNS + 15));
                c.end_y   = COORD_W'(rand_between(-16, SCREEN_ROWS + 15));
            end else if (shape < 92) begin
                bx = rand_between(-8, SCREEN_COLUMNS + 7);
                by = rand_between(-8, SCREEN_ROWS + 7);
                c.start_x = COORD_W'(bx);
                c.start_y = COORD_W'(by);
                c.end_x   = COORD_W'(bx + rand_between(-6, 6));
                c.end_y   = COORD_W'(by + rand_between(-6, 6));
            end
            // remaining shapes keep the full-range coordinates
            c.ink  = ($urandom_range(0, 3) != 0);
            last_x = int'(c.start_x);
            last_y = int'(c.start_y);
        end else if (pick < 90) begin
            c.opcode = OP_READ;
            if ($urandom_range(0, 1) == 1 && last_x >= 0 && last_x < SCREEN_COLUMNS &&
                last_y >= 0 && last_y < SCREEN_ROWS)
                c.read_index = ADDR_W'(last_x + (last_y / 8) * SCREEN_COLUMNS);
        end else if (pick < 94) begin
            c.opcode = OP_CLEAR;
        end else begin
            c.opcode = OP_UNUSED;
        end
        return c;
    endfunction

    // offer one request, queue its expected result when taken
    task automatic send_request(input line_cmd_t c, input bit typed, input fb_result_t want);
        fb_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.read_index, c.ink, c.end_y, c.end_x,
                     c.start_y, c.start_x, c.opcode};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_command(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // bursts of requests with idle gaps, now and then a long unbroken burst
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
        end
    endtask

    // stop offering until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     what, results_seen, exp_v, act_v);
    endtask

    // result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        fb_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unrequested result", '0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[BYTE_W-1:0] !== want.read_byte)
                    flag_mismatch("read_byte", want.read_byte, m_tdata[BYTE_W-1:0]);
                if (m_tdata[BYTE_W +: CNT_W] !== want.pixels_written)
                    flag_mismatch("pixels_written", want.pixels_written,
                                  m_tdata[BYTE_W +: CNT_W]);
            end
        end
    end

    // receiver stalls in stretches of varying density, plus one long hold-off
    initial begin : receiver
        rx_pattern_t pattern;
        int          stretch;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            stretch = $urandom_range(4, 60);
            pattern = rx_pattern_t'($urandom_range(0, 3));
            repeat (stretch) begin
                @(posedge aclk);
                case (pattern)
                    RX_FREE:  m_tready <= 1'b1;
                    RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  m_tready <= 1'($urandom_range(0, 1));
                    RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:  m_tready <= 1'b1;
                endcase
            end
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES)
                    @(posedge aclk);
                long_hold_done = 1'b1;
            end
        end
    end

    // reset, directed table, random requests, final verdict
    initial begin : stimulus
        fb_result_t no_result;
        line_cmd_t  c;
        no_result.read_byte      = '0;
        no_result.pixels_written = '0;
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;

        // store empty after reset
        add_row(OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00,   0);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h00,   0);
        // single pixels at both screen corners
        add_row(OP_DRAW,     0,    0,    0,    0, 1'b1,    0, 1'b1, 8'h00,   1);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h01,   0);
        add_row(OP_DRAW,   127,   63,  127,   63, 1'b1,    0, 1'b1, 8'h00,   1);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h80,   0);
        // single pixels just off the left, right and bottom edges
        add_row(OP_DRAW,    -1,    5,   -1,    5, 1'b1,    0, 1'b1, 8'h00,   0);
        add_row(OP_DRAW,   128,    0,  128,    0, 1'b1,    0, 1'b1, 8'h00,   0);
        add_row(OP_DRAW,     0,   64,    0,   64, 1'b1,    0, 1'b1, 8'h00,   0);
        // full-width row and full-height column
        add_row(OP_DRAW,     0,    8,  127,    8, 1'b1,    0, 1'b1, 8'h00, 128);
        add_row(OP_DRAW,     5,   63,    5,    0, 1'b1,    0, 1'b1, 8'h00,  64);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0,  133, 1'b0, 8'h00,   0);
        // clearing ink on one pixel
        add_row(OP_DRAW,     5,    8,    5,    8, 1'b0,    0, 1'b1, 8'h00,   1);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0,  133, 1'b0, 8'h00,   0);
        // coordinate extremes, mostly clipped
        add_row(OP_DRAW,  -512, -512,  511,  511, 1'b1,    0, 1'b0, 8'h00,   0);
        add_row(OP_DRAW,   511, -512, -512,  511, 1'b1,    0, 1'b0, 8'h00,   0);
        add_row(OP_DRAW,    10, -100,   20,  200, 1'b1,    0, 1'b0, 8'h00,   0);
        add_row(OP_DRAW,  -512,   16,  511,   16, 1'b1,    0, 1'b1, 8'h00, 128);
        add_row(OP_DRAW,   100,  511,  -50, -512, 1'b0,    0, 1'b0, 8'h00,   0);
        // unused opcode and unused fields
        add_row(OP_UNUSED,  -1,   -1,   -1,   -1, 1'b1, 1023, 1'b1, 8'h00,   0);
        add_row(OP_READ,   -77,  300, -512,  511, 1'b1,  136, 1'b0, 8'h00,   0);
        // clear with junk in every other field, then store empty again
        add_row(OP_CLEAR,  511, -512,  -33,   47, 1'b1,  777, 1'b1, 8'h00,   0);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h00,   0);
        add_row(OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00,   0);

        repeat (5)
            @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            c = random_command();
            send_request(c, 1'b0, no_result);
            pace_sender();
            if (n == DRAIN_AT)
                wait_for_results();
        end
        wait_for_results();

        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
